// File: hw/rtl/tsrr_pkg.sv
// Shared types and constants for the task slot round-robin scheduler.
// No dependencies; used by task_slot_round_robin_scheduler_unit, tsrr_checker and tb_top.
`default_nettype none

package tsrr_pkg;

    // Field widths of the stream payloads
    localparam int SLOT_W      = 10;
    localparam int REQ_W       = 2;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;

    // Default table size
    localparam int NUM_SLOTS_DEF = 1024;

    // Slot status codes held in the status memory
    localparam logic [1:0] STAT_FREE  = 2'd0;
    localparam logic [1:0] STAT_ALLOC = 2'd1;
    localparam logic [1:0] STAT_RUN   = 2'd2;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_SCHED = 2'd2
    } req_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/task_slot_round_robin_scheduler_unit.sv
// Task slot round-robin scheduler: status memory, scan sequencer and stream ports.
// Depends on tsrr_pkg.
`default_nettype none

// After reset the block sweeps the slot status memory, one entry per cycle, and takes no
// transaction until the sweep is done. Allocate and schedule requests scan the status
// memory through its single registered read port, one slot per cycle. A scan stops at its
// first hit, or with nothing found once every slot has been tested. Make-runnable and
// unused request codes go straight to the result without a scan. One request is handled
// at a time. The next transaction is accepted at the earliest in the cycle after the result
// is loaded, while that result may still wait in the output register. A result that cannot
// be loaded because the output register is still held stalls the sequencer.
module task_slot_round_robin_scheduler_unit #(
    parameter int NUM_SLOTS = tsrr_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // tdata: [1:0] req_type, [11:2] slot, [15:12] zero
    input  wire logic [tsrr_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tdata: [0] found, [10:1] result_slot, [20:11] previous_slot, [23:21] zero
    output logic [tsrr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);

    localparam int IDX_W  = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int EXT_W  = IDX_W + tsrr_pkg::SLOT_W;
    localparam int PAD_W  = tsrr_pkg::M_TDATA_W - 1 - 2 * tsrr_pkg::SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(NUM_SLOTS);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(NUM_SLOTS - 1);
    localparam logic [EXT_W-1:0] SLOTS_EXT = EXT_W'(NUM_SLOTS);

    // Slot status memory
    logic [1:0] status_mem [NUM_SLOTS];

    tsrr_pkg::state_t state_reg, state_next;
    tsrr_pkg::req_t   req_reg, req_next;

    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] chk_reg, chk_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [1:0]       rd_data_reg;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] res_reg, res_next;
    logic [IDX_W-1:0] prev_reg, prev_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [tsrr_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Memory write port
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [1:0]       wr_data;

    // Decode and scan control
    logic                    s_accept;
    logic                    out_load;
    tsrr_pkg::req_t          s_req;
    logic [tsrr_pkg::SLOT_W-1:0] s_slot;
    logic [EXT_W-1:0]        s_slot_ext;
    logic [1:0]              target;
    logic                    hit;
    logic                    miss_all;
    logic                    issue;
    logic [EXT_W-1:0]        res_ext;
    logic [EXT_W-1:0]        prev_ext;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (idx == LAST_IDX) begin
            r = '0;
        end else begin
            r = idx + IDX_W'(1);
        end
        return r;
    endfunction

    assign s_req      = tsrr_pkg::req_t'(s_tdata[tsrr_pkg::REQ_W-1:0]);
    assign s_slot     = s_tdata[tsrr_pkg::REQ_W +: tsrr_pkg::SLOT_W];
    assign s_slot_ext = {{IDX_W{1'b0}}, s_slot};
    assign s_accept   = s_tvalid && s_tready;
    assign out_load   = (state_reg == tsrr_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);

    // Scan compare: allocate looks for a free slot, schedule for a runnable one
    assign target   = (req_reg == tsrr_pkg::REQ_ALLOC) ? tsrr_pkg::STAT_FREE
                                                       : tsrr_pkg::STAT_RUN;
    assign hit      = (state_reg == tsrr_pkg::ST_SCAN) && rd_vld_reg && (rd_data_reg == target);
    assign miss_all = (state_reg == tsrr_pkg::ST_SCAN) && rd_vld_reg && !hit
                      && (chk_reg == CNT_LAST);
    assign issue    = (state_reg == tsrr_pkg::ST_SCAN) && (cnt_reg != CNT_FULL)
                      && !hit && !miss_all;

    assign res_ext  = {{tsrr_pkg::SLOT_W{1'b0}}, res_reg};
    assign prev_ext = {{tsrr_pkg::SLOT_W{1'b0}}, prev_reg};

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tsrr_pkg::ST_CLEAR: begin
                if (addr_reg == LAST_IDX) begin
                    state_next = tsrr_pkg::ST_IDLE;
                end
            end
            tsrr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_req == tsrr_pkg::REQ_ALLOC || s_req == tsrr_pkg::REQ_SCHED) begin
                        state_next = tsrr_pkg::ST_SCAN;
                    end else begin
                        state_next = tsrr_pkg::ST_DONE;
                    end
                end
            end
            tsrr_pkg::ST_SCAN: begin
                if (hit || miss_all) begin
                    state_next = tsrr_pkg::ST_DONE;
                end
            end
            tsrr_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = tsrr_pkg::ST_IDLE;
                end
            end
            default: state_next = tsrr_pkg::ST_IDLE;
        endcase
    end

    // State-decoded outputs
    always_comb begin
        s_tready = (state_reg == tsrr_pkg::ST_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata  = m_tdata_reg;
    end

    // Datapath and memory port control
    always_comb begin
        req_next      = req_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        chk_next      = chk_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        cur_next      = cur_reg;
        found_next    = found_reg;
        res_next      = res_reg;
        prev_next     = prev_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        wr_en         = 1'b0;
        wr_addr       = addr_reg;
        wr_data       = tsrr_pkg::STAT_FREE;

        case (state_reg)
            tsrr_pkg::ST_CLEAR: begin
                wr_en     = 1'b1;
                addr_next = next_idx(addr_reg);
            end
            tsrr_pkg::ST_IDLE: begin
                if (s_accept) begin
                    req_next   = s_req;
                    found_next = 1'b0;
                    res_next   = '0;
                    prev_next  = '0;
                    cnt_next   = '0;
                    chk_next   = '0;
                    case (s_req)
                        tsrr_pkg::REQ_ALLOC: begin
                            addr_next = '0;
                        end
                        tsrr_pkg::REQ_SCHED: begin
                            addr_next = next_idx(cur_reg);
                            prev_next = cur_reg;
                            res_next  = cur_reg;
                        end
                        tsrr_pkg::REQ_RUN: begin
                            if (s_slot_ext < SLOTS_EXT) begin
                                wr_en   = 1'b1;
                                wr_addr = s_slot_ext[IDX_W-1:0];
                                wr_data = tsrr_pkg::STAT_RUN;
                            end
                        end
                        default: begin
                            addr_next = addr_reg;
                        end
                    endcase
                end
            end
            tsrr_pkg::ST_SCAN: begin
                rd_vld_next = issue;
                if (issue) begin
                    rd_idx_next = addr_reg;
                    addr_next   = next_idx(addr_reg);
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                chk_next = chk_reg + CNT_W'(rd_vld_reg);
                if (hit) begin
                    found_next = 1'b1;
                    res_next   = rd_idx_reg;
                    if (req_reg == tsrr_pkg::REQ_ALLOC) begin
                        wr_en   = 1'b1;
                        wr_addr = rd_idx_reg;
                        wr_data = tsrr_pkg::STAT_ALLOC;
                    end else begin
                        cur_next = rd_idx_reg;
                    end
                end
            end
            tsrr_pkg::ST_DONE: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}},
                                     prev_ext[tsrr_pkg::SLOT_W-1:0],
                                     res_ext[tsrr_pkg::SLOT_W-1:0],
                                     found_reg};
                end
            end
            default: begin
                rd_vld_next = 1'b0;
            end
        endcase
    end

    // Status memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            status_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= status_mem[addr_reg];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tsrr_pkg::ST_CLEAR;
            addr_reg     <= '0;
            cnt_reg      <= '0;
            chk_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            cur_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            cnt_reg      <= cnt_next;
            chk_reg      <= chk_next;
            rd_vld_reg   <= rd_vld_next;
            cur_reg      <= cur_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        rd_idx_reg  <= rd_idx_next;
        found_reg   <= found_next;
        res_reg     <= res_next;
        prev_reg    <= prev_next;
        m_tdata_reg <= m_tdata_next;
    end

    // No transaction is taken while the memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tsrr_pkg::ST_CLEAR) |-> !s_tready)
        else $error("input accepted during clearing pass");

    // A schedule scan that finds nothing keeps the current task
    a_miss_keeps_current: assert property (@(posedge aclk) disable iff (!aresetn)
        (miss_all && req_reg == tsrr_pkg::REQ_SCHED) |=> $stable(cur_reg))
        else $error("current task changed on empty schedule");

    // Slots tested never outrun reads issued
    a_chk_le_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tsrr_pkg::ST_SCAN) |-> (chk_reg <= cnt_reg))
        else $error("scan check count ahead of read count");

    // A finished result waits while the output register is still held
    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tsrr_pkg::ST_DONE && m_tvalid_reg && !m_tready)
        |=> (state_reg == tsrr_pkg::ST_DONE))
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire

// File: test/tsrr_checker.sv
// Checker for the task slot round-robin scheduler: watches both stream channels, keeps its
// own copy of the slot table and current task, and compares every reply field by field.
// Depends on tsrr_pkg.
module tsrr_checker #(
    parameter int NUM_SLOTS = tsrr_pkg::NUM_SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [tsrr_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [tsrr_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           end_of_run,
    output int                             fail_count,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import tsrr_pkg::*;

    localparam int MAX_PRINTED = 200;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot_out;
        logic [SLOT_W-1:0] prev_slot;
    } reply_t;

    // Shadow of the scheduler state
    logic [1:0]        slot_state [NUM_SLOTS];
    logic [SLOT_W-1:0] current_slot;

    reply_t replies_due[$];
    reply_t due_reply;
    reply_t seen_reply;
    int     reply_index;
    bit     leftover_checked;

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic flag_mismatch(input string what);
        if (fail_count < MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    // Applies one request to the shadow state and works out the reply it gives
    task automatic schedule_reply(input logic [S_TDATA_W-1:0] word, output reply_t r);
        logic [REQ_W-1:0]  code;
        logic [SLOT_W-1:0] idx;
        int                probe;
        bit                hit;
        code = word[REQ_W-1:0];
        idx  = word[REQ_W+SLOT_W-1:REQ_W];
        hit  = 1'b0;
        r    = '0;
        case (code)
            REQ_ALLOC: begin
                // lowest free slot wins
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (!hit && slot_state[i] == STAT_FREE) begin
                        slot_state[i] = STAT_ALLOC;
                        hit           = 1'b1;
                        r.found       = 1'b1;
                        r.slot_out    = i[SLOT_W-1:0];
                    end
                end
            end
            REQ_RUN: begin
                if (int'(idx) < NUM_SLOTS)
                    slot_state[idx] = STAT_RUN;
            end
            REQ_SCHED: begin
                // round robin from the slot after the current one; current slot tested last
                r.prev_slot = current_slot;
                for (int k = 1; k <= NUM_SLOTS; k++) begin
                    probe = (int'(current_slot) + k) % NUM_SLOTS;
                    if (!hit && slot_state[probe] == STAT_RUN) begin
                        current_slot = probe[SLOT_W-1:0];
                        hit          = 1'b1;
                        r.found      = 1'b1;
                    end
                end
                r.slot_out = current_slot;
            end
            default: ;
        endcase
    endtask

    // Result side first: a reply can never belong to a request taken at the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++)
                slot_state[i] = STAT_FREE;
            current_slot     = '0;
            reply_index      = 0;
            leftover_checked = 1'b0;
            replies_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen_reply.found     = m_tdata[0];
                seen_reply.slot_out  = m_tdata[SLOT_W:1];
                seen_reply.prev_slot = m_tdata[2*SLOT_W:SLOT_W+1];
                if (replies_due.size() == 0) begin
                    flag_mismatch($sformatf("reply %0d arrived with nothing expected",
                                            reply_index));
                end else begin
                    due_reply = replies_due.pop_front();
                    if (seen_reply.found !== due_reply.found)
                        flag_mismatch($sformatf("reply %0d found: got %0b, expected %0b",
                                                reply_index, seen_reply.found,
                                                due_reply.found));
                    if (seen_reply.slot_out !== due_reply.slot_out)
                        flag_mismatch($sformatf("reply %0d result_slot: got %0d, expected %0d",
                                                reply_index, seen_reply.slot_out,
                                                due_reply.slot_out));
                    if (seen_reply.prev_slot !== due_reply.prev_slot)
                        flag_mismatch($sformatf("reply %0d previous_slot: got %0d, expected %0d",
                                                reply_index, seen_reply.prev_slot,
                                                due_reply.prev_slot));
                end
                reply_index++;
            end
            if (s_tvalid && s_tready) begin
                schedule_reply(s_tdata, due_reply);
                replies_due.push_back(due_reply);
            end
            if (end_of_run && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (replies_due.size() != 0)
                    flag_mismatch($sformatf("%0d replies never arrived", replies_due.size()));
            end
        end
        outstanding <= replies_due.size();
    end

endmodule

// File: test/tb_top.sv
// Top of the scheduler testbench: clock, reset, request stimulus, reply back-pressure and
// the verdict. Depends on tsrr_pkg, task_slot_round_robin_scheduler_unit and tsrr_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tsrr_pkg::*;

    localparam int SLOTS       = NUM_SLOTS_DEF;
    localparam int HOLD_CYCLES = 1500;
    localparam int LIMIT       = 6_000_000;
    localparam int PHASE_ITEMS = 180;

    // request code the block must ignore
    localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 end_of_run = 1'b0;

    int fail_count;
    int outstanding;
    int cycle_count    = 0;
    int send_idle_pct  = 11;
    int recv_idle_pct  = 71;
    int hold_requests  = 0;
    int holds_served   = 0;

    task_slot_round_robin_scheduler_unit #(
        .NUM_SLOTS(SLOTS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    tsrr_checker #(
        .NUM_SLOTS(SLOTS)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .end_of_run (end_of_run),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT);
        $display("[task_slot_round_robin_scheduler_unit] ERROR");
        $finish;
    end

    // Reply side back-pressure, with an occasional long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                m_tready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One request transaction, preceded by random idle cycles
    task automatic send_req(input logic [REQ_W-1:0] code, input logic [SLOT_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-REQ_W-SLOT_W){1'b0}}, idx, code};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and wait until every reply is back
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    // Random request mix; slot indices mostly packed low so schedules see many runnables
    task automatic send_random(input int n);
        int                pick;
        logic [REQ_W-1:0]  code;
        logic [SLOT_W-1:0] idx;
        repeat (n) begin
            pick = int'($urandom_range(99));
            if (pick < 25)
                code = REQ_ALLOC;
            else if (pick < 60)
                code = REQ_RUN;
            else if (pick < 95)
                code = REQ_SCHED;
            else
                code = REQ_NONE;
            if ($urandom_range(3) == 0)
                idx = SLOT_W'($urandom_range(SLOTS - 1));
            else
                idx = SLOT_W'($urandom_range(63));
            send_req(code, idx);
        end
    endtask

    initial begin
        // reset
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, lone runnable current slot, wrap-around, unused code
        send_req(REQ_SCHED, 10'h3FF);
        send_req(REQ_RUN,   10'd0);
        send_req(REQ_SCHED, 10'd0);
        send_req(REQ_ALLOC, 10'd0);
        send_req(REQ_ALLOC, 10'h3FF);
        send_req(REQ_RUN,   10'd2);
        send_req(REQ_RUN,   10'h3FF);
        send_req(REQ_RUN,   10'd2);
        send_req(REQ_SCHED, 10'd0);
        send_req(REQ_SCHED, 10'd0);
        send_req(REQ_SCHED, 10'h3FF);
        send_req(REQ_ALLOC, 10'd0);
        send_req(REQ_NONE,  10'h3FF);
        send_req(REQ_NONE,  10'd0);
        send_req(REQ_RUN,   10'h2AA);
        send_req(REQ_RUN,   10'h155);
        send_req(REQ_SCHED, 10'h155);
        send_req(REQ_SCHED, 10'h2AA);
        send_req(REQ_SCHED, 10'd0);
        send_req(REQ_ALLOC, 10'd0);

        // busy sender, reluctant receiver; long receiver hold-off fills the block
        send_random(PHASE_ITEMS / 2);
        hold_requests <= hold_requests + 1;
        repeat (16)
            send_req(REQ_RUN, SLOT_W'($urandom_range(SLOTS - 1)));
        send_random(PHASE_ITEMS / 2);
        drain_replies();

        // roles swapped
        send_idle_pct = 71;
        recv_idle_pct = 11;
        send_random(PHASE_ITEMS);
        drain_replies();

        // no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(PHASE_ITEMS);

        // wind down: nothing pending, then a full scan's worth of quiet cycles
        drain_replies();
        repeat (SLOTS + 16) @(posedge aclk);
        end_of_run <= 1'b1;
        repeat (2) @(posedge aclk);
        if (fail_count == 0)
            $display("[task_slot_round_robin_scheduler_unit] OK");
        else
            $display("[task_slot_round_robin_scheduler_unit] ERROR");
        $finish;
    end

endmodule
